// File: rtl/core/reed_solomon_ecc_encoder_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef REED_SOLOMON_ECC_ENCODER_UNIT_DEFINES_SVH
`define REED_SOLOMON_ECC_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset
`define RSE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rse assertion failed");

// Next-cycle implication, masked during reset
`define RSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rse assertion failed");

// Next-cycle implication, live during reset
`define RSE_ASSERT_RESET(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rse reset assertion failed");

`endif

// File: rtl/core/rse_pkg.sv
package rse_pkg;

   localparam int unsigned RSE_MAX_ECC_BYTES = 30;
   localparam int unsigned RSE_GF_POLY       = 285;
   localparam int unsigned RSE_MIN_ECC       = 2;
   localparam logic [4:0]  RSE_ECC_RESET     = 5'd10;

   // GF(256) multiply, shift-and-add with reduction by poly
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                         input logic [8:0] poly);
      logic [8:0] x;
      logic [7:0] acc;
      x   = {1'b0, a};
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x[7:0];
         end
         x = {x[7:0], 1'b0};
         if (x[8]) begin
            x = x ^ poly;
         end
         x[8] = 1'b0;
      end
      return acc;
   endfunction

endpackage

// File: rtl/core/rse_gen_rom.sv
module rse_gen_rom #(
   parameter int unsigned MAX_ECC_BYTES = rse_pkg::RSE_MAX_ECC_BYTES,
   parameter int unsigned GF_POLY       = rse_pkg::RSE_GF_POLY,
   parameter int unsigned CW            = $clog2(MAX_ECC_BYTES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_fire,
   input  logic [4:0]                 csr_data,
   output logic [CW-1:0]              ecc_n,
   output logic [MAX_ECC_BYTES*8-1:0] gen_row
);
   import rse_pkg::*;

   localparam logic [8:0] POLY = GF_POLY[8:0];

   typedef logic [MAX_ECC_BYTES:0][MAX_ECC_BYTES:0][7:0] gen_table_type;

   // Build generator coefficients for every count, highest order first
   function automatic gen_table_type build_table();
      gen_table_type t;
      logic [7:0]    c [0:MAX_ECC_BYTES];
      logic [7:0]    root;
      for (int n = 0; n <= MAX_ECC_BYTES; n++) begin
         c[n] = '0;
         for (int j = 0; j <= MAX_ECC_BYTES; j++) begin
            t[n][j] = '0;
         end
      end
      c[0] = 8'h01;
      root = 8'h01;
      for (int n = 1; n <= MAX_ECC_BYTES; n++) begin
         for (int j = n; j >= 1; j--) begin
            c[j] = c[j] ^ gf_mul(root, c[j-1], POLY);
         end
         for (int j = 0; j <= n; j++) begin
            t[n][j] = c[j];
         end
         root = gf_mul(root, 8'h02, POLY);
      end
      return t;
   endfunction

   localparam gen_table_type GEN_TABLE = build_table();

   // Clamp the written count into the supported range
   function automatic logic [CW-1:0] clamp_count(input logic [4:0] v);
      int unsigned x;
      x = 32'(v);
      if (x < RSE_MIN_ECC) begin
         x = RSE_MIN_ECC;
      end
      if (x > MAX_ECC_BYTES) begin
         x = MAX_ECC_BYTES;
      end
      return CW'(x);
   endfunction

   logic [CW-1:0]              n_ff, n_in, sel;
   logic [MAX_ECC_BYTES*8-1:0] row_ff, row_in;

   // Select the table row for the new count
   always_comb begin
      sel  = clamp_count(reset ? RSE_ECC_RESET : csr_data);
      n_in = sel;
      for (int k = 1; k <= MAX_ECC_BYTES; k++) begin
         row_in[(k-1)*8 +: 8] = GEN_TABLE[sel][k];
      end
   end

   // Hold count and coefficient row until the next register write
   always_ff @(posedge clock) begin
      if (reset || csr_fire) begin
         n_ff   <= n_in;
         row_ff <= row_in;
      end
   end

   assign ecc_n   = n_ff;
   assign gen_row = row_ff;

endmodule

// File: rtl/core/rse_divider.sv
module rse_divider #(
   parameter int unsigned MAX_ECC_BYTES = rse_pkg::RSE_MAX_ECC_BYTES,
   parameter int unsigned GF_POLY       = rse_pkg::RSE_GF_POLY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,
   input  logic                       req_tlast,
   input  logic                       csr_fire,
   input  logic [MAX_ECC_BYTES*8-1:0] gen_row,
   input  logic                       drain_free,
   output logic                       load,
   output logic [MAX_ECC_BYTES*8-1:0] load_bytes
);
   import rse_pkg::*;

   localparam logic [8:0] POLY = GF_POLY[8:0];

   logic                       in_valid_ff;
   logic [7:0]                 in_data_ff;
   logic                       in_last_ff;
   logic [MAX_ECC_BYTES*8-1:0] rem_ff, rem_in;
   logic [7:0]                 factor;
   logic                       advance;

   // Stall a last byte only while the previous check bytes still drain
   assign advance    = in_valid_ff && (!in_last_ff || drain_free);
   assign req_tready = !in_valid_ff || advance;

   // Shift remainder one byte down and add factor times the generator.
   // Bytes above the active count stay zero, so no masking is needed.
   always_comb begin
      factor = in_data_ff ^ rem_ff[7:0];
      rem_in = {8'h00, rem_ff[MAX_ECC_BYTES*8-1:8]};
      for (int k = 0; k < MAX_ECC_BYTES; k++) begin
         rem_in[k*8 +: 8] = rem_in[k*8 +: 8] ^ gf_mul(factor, gen_row[k*8 +: 8], POLY);
      end
   end

   assign load       = advance && in_last_ff;
   assign load_bytes = rem_in;

   // Capture the incoming transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Advance remainder; clear at block end and on register write
   always_ff @(posedge clock) begin
      if (reset || csr_fire) begin
         rem_ff <= '0;
      end else if (advance) begin
         rem_ff <= in_last_ff ? '0 : rem_in;
      end
   end

endmodule

// File: rtl/core/rse_drain.sv
module rse_drain #(
   parameter int unsigned MAX_ECC_BYTES = rse_pkg::RSE_MAX_ECC_BYTES,
   parameter int unsigned CW            = $clog2(MAX_ECC_BYTES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [MAX_ECC_BYTES*8-1:0] load_bytes,
   input  logic [CW-1:0]              ecc_n,
   output logic                       drain_free,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tlast
);
   import rse_pkg::*;

   logic [MAX_ECC_BYTES*8-1:0] buf_ff;
   logic [CW-1:0]              cnt_ff;
   logic                       fire;

   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = buf_ff[7:0];
   assign rsp_tlast  = cnt_ff == CW'(1);
   assign fire       = rsp_tvalid && rsp_tready;
   assign drain_free = (cnt_ff == '0) || (rsp_tlast && rsp_tready);

   // Load check bytes at block end, shift one out per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= ecc_n;
      end else if (fire) begin
         cnt_ff <= cnt_ff - CW'(1);
      end
      if (load) begin
         buf_ff <= load_bytes;
      end else if (fire) begin
         buf_ff <= {8'h00, buf_ff[MAX_ECC_BYTES*8-1:8]};
      end
   end

endmodule

// File: rtl/core/reed_solomon_ecc_encoder_unit.sv
// Reed-Solomon check-byte encoder over GF(256), systematic, QR generator.
// req channel: one data codeword per transaction in req_tdata, req_tlast on
// the final codeword of a block. rsp channel: the check bytes of the block,
// highest order first, rsp_tlast on the final one. csr channel: writes the
// check-byte count (clamped to 2..MAX_ECC_BYTES) and clears the remainder.
// Throughput: one data codeword per cycle unless a last codeword waits
// on a busy output; the remainder update is one registered pass of
// MAX_ECC_BYTES parallel GF multipliers. The last data codeword passes
// the input register, then the check bytes load into the output shift
// register and leave one per cycle while rsp_tready is high. A following
// block streams in meanwhile, but its last codeword waits in the input
// register until that shift register is empty (or hands off its final byte).
// rsp stall: the output shift register holds; data keeps entering until a
// last codeword meets a busy output, then req_tready drops.
// Reset: count 10, remainder cleared, both channels empty; csr_ready is
// always high.
module reed_solomon_ecc_encoder_unit #(
   parameter int unsigned MAX_ECC_BYTES = rse_pkg::RSE_MAX_ECC_BYTES,
   parameter int unsigned GF_POLY       = rse_pkg::RSE_GF_POLY
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_of_block
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] ecc_byte
   output logic       rsp_tlast,   // last_ecc
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data     // [4:0] ecc_count
);
   import rse_pkg::*;

   localparam int unsigned CW = $clog2(MAX_ECC_BYTES + 1);

   logic                       csr_fire;
   logic [CW-1:0]              ecc_n;
   logic [MAX_ECC_BYTES*8-1:0] gen_row;
   logic                       drain_free;
   logic                       load;
   logic [MAX_ECC_BYTES*8-1:0] load_bytes;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   rse_gen_rom #(
      .MAX_ECC_BYTES (MAX_ECC_BYTES),
      .GF_POLY       (GF_POLY),
      .CW            (CW)
   ) u_gen_rom (
      .clock    (clock),
      .reset    (reset),
      .csr_fire (csr_fire),
      .csr_data (csr_data),
      .ecc_n    (ecc_n),
      .gen_row  (gen_row)
   );

   rse_divider #(
      .MAX_ECC_BYTES (MAX_ECC_BYTES),
      .GF_POLY       (GF_POLY)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_fire   (csr_fire),
      .gen_row    (gen_row),
      .drain_free (drain_free),
      .load       (load),
      .load_bytes (load_bytes)
   );

   rse_drain #(
      .MAX_ECC_BYTES (MAX_ECC_BYTES),
      .CW            (CW)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_bytes (load_bytes),
      .ecc_n      (ecc_n),
      .drain_free (drain_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/core/rse_checker.sv
`include "reed_solomon_ecc_encoder_unit_defines.svh"

module rse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       csr_ready
);

   // Hold a stalled check byte
   `RSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Check bytes of one block leave without gaps
   `RSE_ASSERT_NEXT(a_rsp_burst, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)

   // Input stalls only behind pending check bytes
   `RSE_ASSERT_NOW(a_stall_cause, clock, reset, !req_tready, rsp_tvalid)

   // Leave reset with empty channels
   `RSE_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_tvalid && req_tready && csr_ready)

endmodule

bind reed_solomon_ecc_encoder_unit rse_checker u_rse_checker (.*);
